/* hw/rtl/wpf_pkg.sv */
`default_nettype none
package wpf_pkg;

  localparam int unsigned MaxPoints = 64;
  localparam int unsigned IdxW = $clog2(MaxPoints);
  localparam int unsigned CntW = $clog2(MaxPoints + 1);

  typedef enum logic [2:0] {
    ActClear     = 3'd0,
    ActPushFront = 3'd1,
    ActPushBack  = 3'd2,
    ActMove      = 3'd3,
    ActLength    = 3'd4
  } action_e;

  typedef struct packed {
    logic [2:0]         action;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [31:0]        step;
  } req_t;

  typedef struct packed {
    logic signed [31:0] move_x;
    logic signed [31:0] move_y;
    logic [39:0]        path_length;
    logic [6:0]         point_count;
    logic               finished;
    logic               status;
  } rsp_t;

  // Control between the sequencer and the shared root/divide unit.
  typedef struct packed {
    logic start;
    logic is_div;
  } unit_ctl_t;

endpackage
`default_nettype wire

/* hw/rtl/wpf_unit.sv */
`default_nettype none
// Shared radix-2 unit: a 70-bit restoring square root, or a 64/35 divide.
// One result bit per cycle; also squares operands with one 33x33 multiplier.
// A new start is taken while idle or in the cycle that finishes an operation.
module wpf_unit (
  input  var logic              clk_i,
  input  var logic              rst_ni,
  input  var wpf_pkg::unit_ctl_t ctl_i,
  input  var logic [32:0]       ax_i,
  input  var logic [32:0]       ay_i,
  input  var logic [63:0]       num_i,
  input  var logic [34:0]       den_i,
  output logic                  done_o,
  output logic [34:0]           root_o,
  output logic [32:0]           quot_o
);
  import wpf_pkg::*;

  typedef enum logic [4:0] {
    UIdle = 5'b00001,
    USqA  = 5'b00010,
    USqB  = 5'b00100,
    URoot = 5'b01000,
    UDiv  = 5'b10000
  } ustate_e;

  ustate_e     state_q, state_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [32:0] ax_q, ay_q;
  logic [69:0] rad_q, rad_d;
  logic [71:0] rem_q, rem_d;
  logic [34:0] root_q, root_d;
  logic [63:0] num_q, num_d;
  logic [34:0] den_q;
  logic [32:0] quo_q, quo_d;
  logic [32:0] sq_op;
  logic [65:0] sq;
  logic [71:0] trial;
  logic [35:0] dtrial;
  logic [35:0] drem;

  // square one magnitude per cycle: x first, then y
  assign sq = {33'd0, sq_op} * {33'd0, sq_op};
  assign sq_op = (state_q == USqA) ? ax_q : ay_q;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    rad_d   = rad_q;
    rem_d   = rem_q;
    root_d  = root_q;
    num_d   = num_q;
    quo_d   = quo_q;
    trial   = '0;
    dtrial  = '0;
    drem    = '0;
    case (state_q)
      UIdle: ;
      USqA: begin
        rad_d   = {4'd0, sq};
        state_d = USqB;
      end
      USqB: begin
        rad_d   = rad_q + {4'd0, sq};
        rem_d   = '0;
        root_d  = '0;
        cnt_d   = 6'd34;
        state_d = URoot;
      end
      URoot: begin
        rem_d = {rem_q[69:0], rad_q[69:68]};
        trial = {rem_q[69:0], rad_q[69:68]} - {35'd0, root_q, 2'b01};
        rad_d = {rad_q[67:0], 2'b00};
        if (!trial[71]) begin
          rem_d  = trial;
          root_d = {root_q[33:0], 1'b1};
        end else begin
          root_d = {root_q[33:0], 1'b0};
        end
        cnt_d = cnt_q - 6'd1;
        if (cnt_q == 6'd0) state_d = UIdle;
      end
      UDiv: begin
        drem   = {rem_q[34:0], num_q[63]};
        dtrial = drem - {1'b0, den_q};
        num_d  = {num_q[62:0], 1'b0};
        if (!dtrial[35]) begin
          rem_d = {36'd0, dtrial};
          quo_d = {quo_q[31:0], 1'b1};
        end else begin
          rem_d = {36'd0, drem};
          quo_d = {quo_q[31:0], 1'b0};
        end
        cnt_d = cnt_q - 6'd1;
        if (cnt_q == 6'd0) state_d = UIdle;
      end
      default: state_d = UIdle;
    endcase
    if (ctl_i.start && (state_q == UIdle || done_o)) begin
      if (ctl_i.is_div) begin
        state_d = UDiv;
        cnt_d   = 6'd63;
        num_d   = num_i;
        quo_d   = '0;
        rem_d   = '0;
      end else begin
        state_d = USqA;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= UIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == UIdle || done_o) && ctl_i.start) begin
      ax_q  <= ax_i;
      ay_q  <= ay_i;
      den_q <= den_i;
    end
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
    num_q  <= num_d;
    quo_q  <= quo_d;
  end

  assign done_o = (state_q == URoot || state_q == UDiv) && cnt_q == 6'd0;
  assign root_o = root_d;
  assign quot_o = quo_d;
endmodule
`default_nettype wire

/* hw/rtl/waypoint_path_follower.sv */
`default_nettype none
// Waypoint path follower: a double-ended store of up to 64 Q16.16 points and
// a cursor. Clear, push and unknown actions pass through SRead and SSum to
// SOut. A move or a length query walks segments one at a time through a
// single shared bit-serial unit: a square root per segment, plus a divide
// and scaling on the segment where the move stops. The block is not ready
// while an item is in work; the result waits in an output register and the
// next request is taken in the cycle after the result is taken.
module waypoint_path_follower (
  input  var logic          clk_i,
  input  var logic          rst_ni,
  input  var logic          in_valid_i,
  output logic              in_ready_o,
  input  var wpf_pkg::req_t in_data_i,
  output logic              out_valid_o,
  input  var logic          out_ready_i,
  output wpf_pkg::rsp_t     out_data_o
);
  import wpf_pkg::*;

  typedef enum logic [7:0] {
    SIdle  = 8'b00000001,
    SRead  = 8'b00000010,
    SLoad  = 8'b00000100,
    SRoot  = 8'b00001000,
    SDiv   = 8'b00010000,
    SScale = 8'b00100000,
    SSum   = 8'b01000000,
    SOut   = 8'b10000000
  } state_e;

  state_e           state_q, state_d;
  req_t             req_q;
  logic [IdxW-1:0]  head_q, head_d;
  logic [CntW-1:0]  count_q, count_d;
  logic [CntW-1:0]  cursor_q, cursor_d;
  logic [CntW-1:0]  idx_q, idx_d;
  logic [63:0]      mem [MaxPoints];
  logic [63:0]      rd_q;
  logic             we;
  logic [IdxW-1:0]  waddr, raddr;
  logic [63:0]      wdata;
  logic signed [33:0] px_q, py_q, px_d, py_d;
  logic signed [33:0] dx_q, dy_q, dx_d, dy_d;
  logic signed [40:0] mx_q, my_q, mx_d, my_d;
  logic [40:0]      len_q, len_d;
  logic [31:0]      stepr_q, stepr_d;
  logic [32:0]      rel_q;
  logic             mul_y_q, mul_y_d;
  logic             status_q, status_d;
  rsp_t             rsp_q, rsp_d;
  unit_ctl_t        uctl;
  logic             udone;
  logic [34:0]      uroot;
  logic [32:0]      uquot;
  logic [32:0]      ax, ay;
  logic [65:0]      sprod;
  logic [32:0]      mag;
  logic signed [33:0] sel_d;
  logic signed [33:0] scaled;
  logic             last_move;

  // the unit latches the segment magnitudes at its start
  assign ax = dx_d[33] ? 33'(-dx_d) : dx_d[32:0];
  assign ay = dy_d[33] ? 33'(-dy_d) : dy_d[32:0];

  wpf_unit u_unit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (uctl),
    .ax_i   (ax),
    .ay_i   (ay),
    .num_i  ({stepr_q, 32'd0}),
    .den_i  (uroot),
    .done_o (udone),
    .root_o (uroot),
    .quot_o (uquot)
  );

  // scale one component at a time: 33x33 product, take the high part
  assign sel_d  = mul_y_q ? dy_q : dx_q;
  assign mag    = sel_d[33] ? 33'(-sel_d) : sel_d[32:0];
  assign sprod  = {33'd0, mag} * {33'd0, rel_q};
  assign scaled = sel_d[33] ? -$signed({1'b0, sprod[64:32]}) : $signed({1'b0, sprod[64:32]});

  // address by the next index so rd_q always holds the point at idx_q
  assign raddr = IdxW'(({1'b0, head_q} + idx_d[IdxW:0]) & (MaxPoints - 1));
  assign in_ready_o  = (state_q == SIdle);
  assign out_valid_o = (state_q == SOut);
  assign out_data_o  = rsp_q;

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rd_q <= mem[raddr];
  end

  function automatic logic [31:0] sat32(input logic signed [40:0] v);
    if (v > 41'sd2147483647)       return 32'h7fffffff;
    else if (v < -41'sd2147483648) return 32'h80000000;
    else                           return v[31:0];
  endfunction

  always_comb begin
    state_d  = state_q;
    head_d   = head_q;
    count_d  = count_q;
    cursor_d = cursor_q;
    idx_d    = idx_q;
    px_d = px_q; py_d = py_q; dx_d = dx_q; dy_d = dy_q;
    mx_d = mx_q; my_d = my_q; len_d = len_q;
    stepr_d  = stepr_q;
    mul_y_d  = mul_y_q;
    status_d = status_q;
    rsp_d    = rsp_q;
    uctl     = '0;
    we       = 1'b0;
    waddr    = head_q;
    wdata    = {req_q.point_x, req_q.point_y};
    last_move = 1'b0;
    case (state_q)
      SIdle: begin
        if (in_valid_i) begin
          state_d  = SRead;
          mx_d = '0; my_d = '0; len_d = '0; status_d = 1'b0;
          px_d = 34'(in_data_i.pos_x);
          py_d = 34'(in_data_i.pos_y);
          stepr_d = in_data_i.step;
          idx_d = (in_data_i.action == ActMove) ? cursor_q : '0;
        end
      end
      SRead: begin
        state_d = SSum;
        case (req_q.action)
          ActClear: begin
            head_d = '0; count_d = '0; cursor_d = '0;
          end
          ActPushFront, ActPushBack: begin
            if (count_q >= CntW'(MaxPoints)) status_d = 1'b1;
            else begin
              we = 1'b1;
              if (req_q.action == ActPushFront) begin
                head_d = head_q - IdxW'(1);
                waddr  = head_q - IdxW'(1);
              end else begin
                waddr = IdxW'(({1'b0, head_q} + count_q[IdxW:0]) & (MaxPoints - 1));
              end
              count_d  = count_q + CntW'(1);
              cursor_d = '0;
            end
          end
          ActMove: begin
            if (cursor_q < count_q) state_d = SLoad;
          end
          ActLength: begin
            if (count_q >= CntW'(2)) state_d = SLoad;
          end
          default: ;
        endcase
      end
      SLoad: begin
        // rd_q holds the point at idx_q; a length query first takes point 0
        if (req_q.action == ActLength && idx_q == '0) begin
          px_d = 34'($signed(rd_q[63:32]));
          py_d = 34'($signed(rd_q[31:0]));
          idx_d = CntW'(1);
        end else begin
          dx_d = 34'($signed(rd_q[63:32])) - px_q;
          dy_d = 34'($signed(rd_q[31:0])) - py_q;
          px_d = 34'($signed(rd_q[63:32]));
          py_d = 34'($signed(rd_q[31:0]));
          mul_y_d = 1'b0;
          state_d = SRoot;
        end
      end
      SRoot: begin
        if (udone) begin
          if (req_q.action == ActLength) begin
            len_d = len_q + 41'(uroot);
            idx_d = idx_q + CntW'(1);
            if (idx_q + CntW'(1) >= count_q) state_d = SSum;
            else state_d = SLoad;
          end else if ({3'd0, stepr_q} < uroot) begin
            state_d = SDiv;
            uctl.start  = 1'b1;
            uctl.is_div = 1'b1;
          end else begin
            stepr_d = stepr_q - uroot[31:0];
            mx_d = mx_q + 41'(dx_q);
            my_d = my_q + 41'(dy_q);
            cursor_d = cursor_q + CntW'(1);
            idx_d = idx_q + CntW'(1);
            if (cursor_q + CntW'(1) >= count_q) state_d = SSum;
            else state_d = SLoad;
          end
        end
      end
      SDiv: begin
        if (udone) begin
          state_d = SScale;
          mul_y_d = 1'b0;
        end
      end
      SScale: begin
        if (!mul_y_q) begin
          mx_d = mx_q + 41'(scaled);
          mul_y_d = 1'b1;
        end else begin
          my_d = my_q + 41'(scaled);
          mul_y_d = 1'b0;
          last_move = 1'b1;
          state_d = SSum;
        end
      end
      SSum: begin
        rsp_d.move_x = sat32(mx_q);
        rsp_d.move_y = sat32(my_q);
        rsp_d.path_length = len_q[40] ? 40'hff_ffff_ffff : len_q[39:0];
        rsp_d.point_count = count_q;
        rsp_d.finished = (cursor_q >= count_q);
        rsp_d.status = status_q;
        mul_y_d = 1'b0;
        state_d = SOut;
      end
      SOut: begin
        if (out_ready_i) state_d = SIdle;
      end
      default: state_d = SIdle;
    endcase
    // start the root when entering SRoot
    if (state_q == SLoad && state_d == SRoot) uctl.start = 1'b1;
    if (last_move) uctl.start = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= SIdle;
      head_q   <= '0;
      count_q  <= '0;
      cursor_q <= '0;
      mul_y_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      head_q   <= head_d;
      count_q  <= count_d;
      cursor_q <= cursor_d;
      mul_y_q  <= mul_y_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == SIdle && in_valid_i) req_q <= in_data_i;
    if (state_q == SDiv && udone) rel_q <= uquot;
    idx_q <= idx_d;
    px_q <= px_d; py_q <= py_d; dx_q <= dx_d; dy_q <= dy_d;
    mx_q <= mx_d; my_q <= my_d; len_q <= len_d;
    stepr_q <= stepr_d;
    status_q <= status_d;
    rsp_q <= rsp_d;
  end
endmodule
`default_nettype wire

/* hw/rtl/wpf_checker.sv */
`default_nettype none
module wpf_checker (
  input var logic          clk_i,
  input var logic          rst_ni,
  input var logic          in_valid_i,
  input var logic          in_ready_o,
  input var logic          out_valid_o,
  input var logic          out_ready_i,
  input var wpf_pkg::rsp_t out_data_o
);
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o)) else $error("ready while result pending");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o) else $error("ready after request");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result dropped");
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.point_count <= 7'd64) else $error("count overflow");
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.point_count == 7'd0 |-> out_data_o.finished)
    else $error("empty not finished");
endmodule

bind waypoint_path_follower wpf_checker u_wpf_checker (.*);
`default_nettype wire

/* bench/tb.sv */
`timescale 1ns / 100ps
module tb;
  import wpf_pkg::*;

  localparam int unsigned WatchLimit = 20000;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  req_t in_data_i;
  logic out_valid_o;
  logic out_ready_i;
  rsp_t out_data_o;

  waypoint_path_follower dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  // Path predictor plus queue of expected responses.
  class path_scoreboard;
    logic signed [31:0] wp_x [MaxPoints];
    logic signed [31:0] wp_y [MaxPoints];
    int unsigned head;
    int unsigned count;
    int unsigned cursor;
    rsp_t pending[$];
    int errors;

    function void clear_state();
      head = 0;
      count = 0;
      cursor = 0;
    endfunction

    function logic [34:0] seg_dist(logic signed [33:0] dx, logic signed [33:0] dy);
      logic [33:0] ax;
      logic [33:0] ay;
      logic [67:0] sq;
      logic [34:0] r;
      logic [34:0] t;
      ax = dx < 0 ? -dx : dx;
      ay = dy < 0 ? -dy : dy;
      sq = {34'd0, ax} * {34'd0, ax} + {34'd0, ay} * {34'd0, ay};
      r = '0;
      for (int b = 34; b >= 0; b--) begin
        t = r | (35'd1 << b);
        if ({35'd0, t} * {35'd0, t} <= {2'd0, sq}) r = t;
      end
      return r;
    endfunction

    function logic signed [63:0] scale(logic signed [63:0] d, logic [31:0] rel);
      logic [63:0] m;
      logic [95:0] p;
      m = d < 0 ? -d : d;
      p = {32'd0, m} * {64'd0, rel};
      m = p[95:32];
      return d < 0 ? -$signed(m) : $signed(m);
    endfunction

    function logic [31:0] sat32(logic signed [63:0] v);
      if (v > 64'sd2147483647) return 32'h7fffffff;
      if (v < -64'sd2147483648) return 32'h80000000;
      return v[31:0];
    endfunction

    function void note_request(req_t rq);
      logic signed [63:0] mx;
      logic signed [63:0] my;
      logic signed [63:0] px;
      logic signed [63:0] py;
      logic signed [63:0] dx;
      logic signed [63:0] dy;
      logic [63:0] len;
      logic [63:0] stp;
      logic [34:0] d;
      logic [95:0] q;
      int unsigned slot;
      int unsigned ia;
      int unsigned ib;
      rsp_t r;
      mx = 0;
      my = 0;
      len = 0;
      r = '0;
      case (rq.action)
        ActClear: clear_state();
        ActPushFront, ActPushBack: begin
          if (count >= MaxPoints) begin
            r.status = 1'b1;
          end else begin
            if (rq.action == ActPushFront) begin
              head = (head + MaxPoints - 1) % MaxPoints;
              slot = head;
            end else begin
              slot = (head + count) % MaxPoints;
            end
            wp_x[slot] = rq.point_x;
            wp_y[slot] = rq.point_y;
            count++;
            cursor = 0;
          end
        end
        ActMove: begin
          px = rq.pos_x;
          py = rq.pos_y;
          stp = rq.step;
          while (cursor < count) begin
            slot = (head + cursor) % MaxPoints;
            dx = wp_x[slot] - px;
            dy = wp_y[slot] - py;
            d = seg_dist(dx[33:0], dy[33:0]);
            if (stp < d) begin
              q = {stp[31:0], 32'd0} / {61'd0, d};
              mx += scale(dx, q[31:0]);
              my += scale(dy, q[31:0]);
              break;
            end
            stp -= d;
            mx += dx;
            my += dy;
            px = wp_x[slot];
            py = wp_y[slot];
            cursor++;
          end
        end
        ActLength: begin
          for (int unsigned i = 0; i + 1 < count; i++) begin
            ia = (head + i) % MaxPoints;
            ib = (head + i + 1) % MaxPoints;
            dx = wp_x[ia] - wp_x[ib];
            dy = wp_y[ia] - wp_y[ib];
            len += seg_dist(dx[33:0], dy[33:0]);
          end
          if (len > 64'hff_ffff_ffff) len = 64'hff_ffff_ffff;
        end
        default: ;
      endcase
      r.move_x = sat32(mx);
      r.move_y = sat32(my);
      r.path_length = len[39:0];
      r.point_count = count[6:0];
      r.finished = cursor >= count;
      pending = {pending, r};
    endfunction

    function void check_response(rsp_t got);
      rsp_t exp_r;
      if (pending.size() == 0) begin
        $display("%0t: unexpected response %p", $time, got);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (got.move_x !== exp_r.move_x)
        $display("%0t: move_x exp %0d got %0d", $time, exp_r.move_x, got.move_x);
      if (got.move_y !== exp_r.move_y)
        $display("%0t: move_y exp %0d got %0d", $time, exp_r.move_y, got.move_y);
      if (got.path_length !== exp_r.path_length)
        $display("%0t: path_length exp %0d got %0d", $time, exp_r.path_length,
                 got.path_length);
      if (got.point_count !== exp_r.point_count)
        $display("%0t: point_count exp %0d got %0d", $time, exp_r.point_count,
                 got.point_count);
      if (got.finished !== exp_r.finished)
        $display("%0t: finished exp %0b got %0b", $time, exp_r.finished, got.finished);
      if (got.status !== exp_r.status)
        $display("%0t: status exp %0b got %0b", $time, exp_r.status, got.status);
      if (got !== exp_r) errors++;
    endfunction
  endclass

  path_scoreboard sb;
  bit quiet_phase;
  bit hold_long;
  int idle_cycles;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Pick small coordinates mostly so moves walk several segments.
  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      default: return $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
    endcase
  endfunction

  function automatic logic [31:0] rand_step();
    case ($urandom_range(0, 7))
      0: return $urandom();
      1: return 32'hffffffff;
      2: return 32'd0;
      default: return $urandom_range(0, 32'h0030_0000);
    endcase
  endfunction

  // Hold valid across back-to-back requests; drop it only for an idle gap.
  task automatic send_request(req_t rq);
    int gap;
    if (!quiet_phase && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 18);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= rq;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(rq);
  endtask

  task automatic send_op(action_e act, logic [31:0] a, logic [31:0] b,
                         logic [31:0] c, logic [31:0] d, logic [31:0] s);
    req_t rq;
    rq.action = act;
    rq.point_x = a;
    rq.point_y = b;
    rq.pos_x = c;
    rq.pos_y = d;
    rq.step = s;
    send_request(rq);
  endtask

  task automatic send_random(int weight_push);
    req_t rq;
    int pick;
    rq.point_x = rand_coord();
    rq.point_y = rand_coord();
    rq.pos_x = rand_coord();
    rq.pos_y = rand_coord();
    rq.step = rand_step();
    pick = $urandom_range(0, 99);
    if (pick < 2) rq.action = ActClear;
    else if (pick < 2 + weight_push) rq.action = $urandom_range(0, 1) ? ActPushFront : ActPushBack;
    else if (pick < 90) rq.action = ActMove;
    else if (pick < 97) rq.action = ActLength;
    else rq.action = 3'($urandom_range(5, 7));
    send_request(rq);
  endtask

  // Receiver: random stalls, plus one long hold to back up the input.
  initial begin
    int gap;
    out_ready_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_long) begin
        out_ready_i <= 1'b0;
        repeat (400) @(posedge clk_i);
        hold_long = 1'b0;
      end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
        out_ready_i <= 1'b0;
        gap = $urandom_range(1, 18);
        repeat (gap - 1) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_response(out_data_o);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit) begin
      $display("tb failed");
      $finish;
    end
  end

  initial begin
    sb = new();
    sb.clear_state();
    quiet_phase = 1'b0;
    hold_long = 1'b0;
    idle_cycles = 0;
    rst_ni <= 1'b0;
    in_valid_i <= 1'b0;
    in_data_i <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty store, single point, extremes, zero-length segment.
    send_op(ActMove, 0, 0, 0, 0, 32'h10000);
    send_op(ActLength, 0, 0, 0, 0, 0);
    send_op(ActPushBack, 32'h7fffffff, 32'h7fffffff, 0, 0, 0);
    send_op(ActLength, 0, 0, 0, 0, 0);
    send_op(ActPushFront, 32'h80000000, 32'h80000000, 0, 0, 0);
    send_op(ActPushBack, 32'h80000000, 32'h7fffffff, 0, 0, 0);
    send_op(ActPushBack, 32'h80000000, 32'h7fffffff, 0, 0, 0);
    send_op(ActLength, 0, 0, 0, 0, 0);
    send_op(ActMove, 0, 0, 32'h7fffffff, 32'h80000000, 32'hffffffff);
    send_op(ActMove, 0, 0, 32'h80000000, 32'h80000000, 32'hffffffff);
    send_op(ActMove, 0, 0, 32'h80000000, 32'h80000000, 0);
    send_op(action_e'(3'd5), 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff);
    send_op(action_e'(3'd7), 0, 0, 0, 0, 0);
    send_op(ActClear, 0, 0, 0, 0, 0);
    send_op(ActPushBack, 32'h10000, 0, 0, 0, 0);
    send_op(ActPushBack, 32'h10000, 32'h10000, 0, 0, 0);
    send_op(ActMove, 0, 0, 0, 0, 32'h8000);
    send_op(ActMove, 0, 0, 0, 0, 32'h18000);
    send_op(ActMove, 0, 0, 32'h10000, 0, 32'h10000);
    send_op(ActClear, 0, 0, 0, 0, 0);
    // Fill the store to overflow.
    for (int i = 0; i < MaxPoints + 2; i++)
      send_op(i[0] ? ActPushFront : ActPushBack, $urandom_range(0, 32'h40000),
              $urandom_range(0, 32'h40000), 0, 0, 0);
    send_op(ActLength, 0, 0, 0, 0, 0);

    // Long receiver hold while requests keep arriving.
    hold_long = 1'b1;
    for (int i = 0; i < 20; i++) send_random(10);

    for (int i = 0; i < 650; i++) begin
      if (i == 560) quiet_phase = 1'b1;
      send_random(i % 200 < 100 ? 40 : 12);
    end
    in_valid_i <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end
endmodule
